[rtl/drs_pkg.sv]
`default_nettype none

package drs_pkg;

    // default width of the speed references
    localparam int REF_WIDTH_DEF = 32;

    // fault word and ignore mask width
    localparam int FAULT_WIDTH = 16;

    // configuration register indexes
    localparam logic CFG_MASK_A = 1'b0;
    localparam logic CFG_MASK_B = 1'b1;

    // operator command codes
    localparam logic [1:0] CMD_RUN  = 2'd1;
    localparam logic [1:0] CMD_HALT = 2'd2;

    // auto tuning step that means finished
    localparam logic [2:0] TUNE_DONE_STEP = 3'd5;

    // drive operating states
    typedef enum logic [3:0] {
        ST_POWER_ON = 4'd0,
        ST_CALIB    = 4'd1,
        ST_STOP     = 4'd2,
        ST_READY    = 4'd3,
        ST_ACCEL    = 4'd4,
        ST_DECEL    = 4'd5,
        ST_RUN      = 4'd6,
        ST_TUNE     = 4'd7,
        ST_FAULT    = 4'd8
    } t_drive_state;

    // command and status flags of one input word
    typedef struct packed {
        logic [1:0] cmd;
        logic       calibration_done;
        logic       pwm_enabled;
        logic       ramp_rising;
        logic       ramp_falling;
        logic       tune_request;
        logic [2:0] tune_step;
        logic       fault_cleared;
    } t_flags;

    // outcome of one sequencer step
    typedef struct packed {
        t_drive_state state;
        logic         run_flag;
        logic         fault_hit;
    } t_step;

endpackage

`default_nettype wire

[rtl/drs_next.sv]
`default_nettype none

module drs_next #(
    parameter int REF_WIDTH = drs_pkg::REF_WIDTH_DEF
) (
    input  wire drs_pkg::t_drive_state       i_state,
    input  wire                              i_run_flag,
    input  wire drs_pkg::t_flags             i_flags,
    input  wire [REF_WIDTH-1:0]              i_target_reference,
    input  wire [REF_WIDTH-1:0]              i_ramped_reference,
    input  wire [drs_pkg::FAULT_WIDTH-1:0]   i_fault_word_a,
    input  wire [drs_pkg::FAULT_WIDTH-1:0]   i_fault_word_b,
    input  wire [drs_pkg::FAULT_WIDTH-1:0]   i_mask_a,
    input  wire [drs_pkg::FAULT_WIDTH-1:0]   i_mask_b,
    output drs_pkg::t_step                   o_step
);
    import drs_pkg::*;

    logic         refs_eq;
    logic         tgt_zero;
    logic         fault_hit;
    logic         is_run;
    logic         is_stop;
    t_drive_state s;
    t_drive_state n_state;
    logic         n_run;

    // reference compares and unmasked fault detect
    assign refs_eq   = (i_target_reference == i_ramped_reference);
    assign tgt_zero  = (i_target_reference == '0);
    assign fault_hit = |(i_fault_word_a & ~i_mask_a) | |(i_fault_word_b & ~i_mask_b);
    assign is_run    = (i_flags.cmd == CMD_RUN);
    assign is_stop   = (i_flags.cmd == CMD_HALT);

    // fault overrides the current state before the transition rules
    assign s = fault_hit ? ST_FAULT : i_state;

    // transition rules
    always_comb begin
        n_state = s;
        n_run   = i_run_flag;
        case (s)
            ST_POWER_ON: begin
                n_state = ST_CALIB;
                n_run   = 1'b0;
            end
            ST_CALIB: begin
                if (i_flags.calibration_done) begin
                    n_state = ST_STOP;
                end
            end
            ST_STOP: begin
                if (is_run && !tgt_zero) begin
                    if (i_flags.pwm_enabled) begin
                        n_state = ST_ACCEL;
                    end
                    n_run = 1'b1;
                end else if (is_stop && !i_flags.pwm_enabled) begin
                    n_state = ST_READY;
                    n_run   = 1'b0;
                end
            end
            ST_READY: begin
                if (is_run) begin
                    n_state = ST_STOP;
                    n_run   = 1'b1;
                end else if (i_flags.tune_request) begin
                    n_state = ST_TUNE;
                    n_run   = 1'b1;
                end
            end
            ST_ACCEL: begin
                if (refs_eq) begin
                    n_state = ST_RUN;
                end
            end
            ST_DECEL: begin
                if (refs_eq) begin
                    if (tgt_zero) begin
                        n_state = ST_STOP;
                    end else if (is_run) begin
                        n_state = ST_RUN;
                    end
                end else if (i_flags.ramp_rising) begin
                    n_state = ST_ACCEL;
                end
            end
            ST_RUN: begin
                if (refs_eq && tgt_zero) begin
                    n_state = ST_STOP;
                end else if (i_flags.ramp_rising) begin
                    n_state = ST_ACCEL;
                end else if (i_flags.ramp_falling) begin
                    n_state = ST_DECEL;
                end
            end
            ST_TUNE: begin
                if (!i_flags.tune_request && i_flags.tune_step == TUNE_DONE_STEP) begin
                    n_state = ST_STOP;
                end
            end
            ST_FAULT: begin
                n_run = 1'b0;
                if (i_flags.fault_cleared) begin
                    n_state = ST_STOP;
                end
            end
            default: begin
                n_state = s;
                n_run   = i_run_flag;
            end
        endcase
    end

    assign o_step.state     = n_state;
    assign o_step.run_flag  = n_run;
    assign o_step.fault_hit = fault_hit;

endmodule

`default_nettype wire

[rtl/drive_run_state_sequencer_unit.sv]
`default_nettype none

// channel   direction  handshake                   payload
// -------   ---------  --------------------------  -------------------------------------
// input     in         i_in_valid / o_in_stall      i_cmd .. i_fault_cleared
// output    out        o_out_valid / i_out_stall    o_drive_state, o_run_status
// config    in         i_cfg_we                     i_cfg_addr, i_cfg_wdata
//
// one word per cycle while the output is not stalled; a word is registered in the input register,
// stepped through the state logic, and its result is presented on the output from the result registers.
// the state loop is one register stage: state and result update together.
// synchronous active-low reset puts the drive in power-on with run flag and masks clear.
// a stalled output holds its word; the input register keeps taking words while the
// output register can drain or is empty.

module drive_run_state_sequencer_unit #(
    parameter int REF_WIDTH = drs_pkg::REF_WIDTH_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration
    input  wire                             i_cfg_we,
    input  wire                             i_cfg_addr,
    input  wire [drs_pkg::FAULT_WIDTH-1:0]  i_cfg_wdata,
    // input word
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire [1:0]                       i_cmd,
    input  wire signed [REF_WIDTH-1:0]      i_target_reference,
    input  wire signed [REF_WIDTH-1:0]      i_ramped_reference,
    input  wire [drs_pkg::FAULT_WIDTH-1:0]  i_fault_word_a,
    input  wire [drs_pkg::FAULT_WIDTH-1:0]  i_fault_word_b,
    input  wire                             i_calibration_done,
    input  wire                             i_pwm_enabled,
    input  wire                             i_ramp_rising,
    input  wire                             i_ramp_falling,
    input  wire                             i_tune_request,
    input  wire [2:0]                       i_tune_step,
    input  wire                             i_fault_cleared,
    // result word
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [3:0]                      o_drive_state,
    output logic                            o_run_status
);
    import drs_pkg::*;

    logic [FAULT_WIDTH-1:0] r_mask_a;
    logic [FAULT_WIDTH-1:0] r_mask_b;

    logic                   r_in_valid;
    t_flags                 r_flags;
    logic [REF_WIDTH-1:0]   r_tgt;
    logic [REF_WIDTH-1:0]   r_rmp;
    logic [FAULT_WIDTH-1:0] r_fa;
    logic [FAULT_WIDTH-1:0] r_fb;

    t_drive_state           r_state;
    logic                   r_run_flag;
    logic                   r_out_valid;
    logic [3:0]             r_out_state;
    logic                   r_out_run;

    logic                   in_take;
    logic                   advance;
    t_flags                 n_flags;
    t_step                  step;

    // handshake control
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // fault ignore masks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_a <= '0;
            r_mask_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MASK_A: r_mask_a <= i_cfg_wdata;
                CFG_MASK_B: r_mask_b <= i_cfg_wdata;
                default:    r_mask_a <= r_mask_a;
            endcase
        end
    end

    // input register
    assign n_flags.cmd              = i_cmd;
    assign n_flags.calibration_done = i_calibration_done;
    assign n_flags.pwm_enabled      = i_pwm_enabled;
    assign n_flags.ramp_rising      = i_ramp_rising;
    assign n_flags.ramp_falling     = i_ramp_falling;
    assign n_flags.tune_request     = i_tune_request;
    assign n_flags.tune_step        = i_tune_step;
    assign n_flags.fault_cleared    = i_fault_cleared;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_flags <= n_flags;
            r_tgt   <= i_target_reference;
            r_rmp   <= i_ramped_reference;
            r_fa    <= i_fault_word_a;
            r_fb    <= i_fault_word_b;
        end
    end

    // next-state logic
    drs_next #(
        .REF_WIDTH (REF_WIDTH)
    ) u_next (
        .i_state            (r_state),
        .i_run_flag         (r_run_flag),
        .i_flags            (r_flags),
        .i_target_reference (r_tgt),
        .i_ramped_reference (r_rmp),
        .i_fault_word_a     (r_fa),
        .i_fault_word_b     (r_fb),
        .i_mask_a           (r_mask_a),
        .i_mask_b           (r_mask_b),
        .o_step             (step)
    );

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_POWER_ON;
            r_run_flag  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state    <= step.state;
                r_run_flag <= step.run_flag;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_state <= 4'(step.state);
            r_out_run   <= step.run_flag;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_state = r_out_state;
    assign o_run_status  = r_out_run;

    // an unmasked fault lands in fault, or in stop when fault cleared is set, with the run flag clear
    a_fault_forces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && step.fault_hit |=>
            (r_state == ST_FAULT || r_state == ST_STOP) && !r_run_flag)
        else $error("unmasked fault did not force fault handling");

    // the shown result always matches the held state
    a_out_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive_state == 4'(r_state)) && (o_run_status == r_run_flag))
        else $error("result word disagrees with state register");

    // ready and fault never report a pending run
    a_idle_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READY || r_state == ST_FAULT) |-> !r_run_flag)
        else $error("run flag set in ready or fault");

endmodule

`default_nettype wire
